FILE: sv/ile_pkg.sv
package ile_pkg;

    // Field widths of the stream beats
    localparam int KIND_W    = 4;
    localparam int POS_W     = 8;
    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 9;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // Widest cell index the row supports (capacity up to 4096)
    localparam int IDX_MAX_W = 12;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 4'd0,
        KIND_PUSH_BACK  = 4'd1,
        KIND_POP_FRONT  = 4'd2,
        KIND_POP_BACK   = 4'd3,
        KIND_INSERT     = 4'd4,
        KIND_DELETE     = 4'd5,
        KIND_READ       = 4'd6,
        KIND_WRITE      = 4'd7,
        KIND_READ_FRONT = 4'd8,
        KIND_READ_BACK  = 4'd9
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_RANGE = 2'd2,
        STATUS_FULL  = 2'd3
    } status_t;

    // What every cell of the row does on the next edge
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_SHIFT_UP   = 2'd1,
        CELL_SHIFT_DOWN = 2'd2,
        CELL_WRITE      = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic [IDX_MAX_W-1:0]   idx;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_WAIT  = 2'd1,
        ST_APPLY = 2'd2
    } state_t;

endpackage

FILE: sv/ile_cell.sv
module ile_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  logic                    aclk,
    input  ile_pkg::cell_ctl_t      ctl,
    input  logic [DATA_WIDTH-1:0]   load_word,
    input  logic [DATA_WIDTH-1:0]   prev_word,
    input  logic [DATA_WIDTH-1:0]   next_word,
    output logic [DATA_WIDTH-1:0]   word
);
    import ile_pkg::*;

    localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(INDEX);

    logic [DATA_WIDTH-1:0] word_reg;
    logic [DATA_WIDTH-1:0] word_next;

    // Take the neighbor's word or the new word depending on the broadcast op
    always_comb begin
        word_next = word_reg;
        case (ctl.op)
            CELL_SHIFT_UP: begin
                if (MY_IDX > ctl.idx) begin
                    word_next = prev_word;
                end else if (MY_IDX == ctl.idx) begin
                    word_next = load_word;
                end
            end
            CELL_SHIFT_DOWN: begin
                if (MY_IDX >= ctl.idx) begin
                    word_next = next_word;
                end
            end
            CELL_WRITE: begin
                if (MY_IDX == ctl.idx) begin
                    word_next = load_word;
                end
            end
            default: word_next = word_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

FILE: sv/ile_read_tree.sv
module ile_read_tree #(
    parameter int DATA_WIDTH = 32,
    parameter int CAPACITY   = 256
) (
    input  logic                        aclk,
    input  logic [DATA_WIDTH-1:0]       cell_word [CAPACITY],
    input  logic [$clog2(CAPACITY)-1:0] sel,
    output logic [DATA_WIDTH-1:0]       root
);
    localparam int IW = $clog2(CAPACITY);
    localparam int P  = 1 << IW;

    logic [DATA_WIDTH-1:0] leaf     [P];
    logic [DATA_WIDTH-1:0] node_reg [1:P-1];

    // Leaves: only the selected cell passes its word
    for (genvar j = 0; j < P; j++) begin : g_leaf
        if (j < CAPACITY) begin : g_used
            assign leaf[j] = (sel == IW'(j)) ? cell_word[j] : '0;
        end else begin : g_pad
            assign leaf[j] = '0;
        end
    end

    // Registered OR tree with a register at every level; root is the top node
    for (genvar i = 1; i < P; i++) begin : g_node
        if (2 * i >= P) begin : g_bottom
            always_ff @(posedge aclk) begin
                node_reg[i] <= leaf[2*i-P] | leaf[2*i+1-P];
            end
        end else begin : g_inner
            always_ff @(posedge aclk) begin
                node_reg[i] <= node_reg[2*i] | node_reg[2*i+1];
            end
        end
    end

    assign root = node_reg[1];

endmodule

FILE: sv/indexed_list_engine_top.sv
// Channel  Dir  Bits  Contents
// s_axis   in   48    kind[3:0], position[11:4], write_data[43:12]
// m_axis   out  48    read_data[31:0], status[33:32], count[42:34], empty_flag[43]
//
// One request at a time: after the accepting edge, the request waits in ST_WAIT
// while the registered read tree settles, then ST_APPLY loads the result
// beat; s_tready is back only in ST_IDLE after that, so a new request is
// taken only once the last one has been applied.
// Insert and delete shift the cells from the given position on, in the apply step.
// aresetn is synchronous, active low; it empties the list. A held result beat
// stalls the apply step of the next request, and s_tready stays low meanwhile.
module indexed_list_engine_top #(
    parameter int CAPACITY   = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // kind[3:0], position[11:4], write_data[43:12]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // read_data[31:0], status[33:32], count[42:34], empty_flag[43]
);
    import ile_pkg::*;

    localparam int IW     = $clog2(CAPACITY);
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int WAIT_W = $clog2(IW + 1);

    // Input beat fields
    logic [KIND_W-1:0]    s_kind;
    logic [POS_W-1:0]     s_pos;
    logic [IN_DATA_W-1:0] s_wdata;
    logic [DATA_WIDTH+IN_DATA_W-1:0] s_wdata_wide;

    assign s_kind       = s_tdata[KIND_W-1:0];
    assign s_pos        = s_tdata[KIND_W+POS_W-1:KIND_W];
    assign s_wdata      = s_tdata[KIND_W+POS_W+IN_DATA_W-1:KIND_W+POS_W];
    assign s_wdata_wide = {{DATA_WIDTH{1'b0}}, s_wdata};

    // Control and request registers
    state_t                state_reg, state_next;
    logic [WAIT_W-1:0]     wait_reg, wait_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [KIND_W-1:0]     kind_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [DATA_WIDTH-1:0] wdata_reg;
    logic [IW-1:0]         sel_reg, sel_next;
    logic                  m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]  m_data_reg, m_data_next;

    logic accept;
    logic load;

    // Cell row
    logic [DATA_WIDTH-1:0] cell_word [CAPACITY];
    logic [DATA_WIDTH-1:0] tree_root;
    cell_ctl_t             cell_ctl;

    // Index helpers
    logic [CW-1:0]       count_dec;
    logic [IW-1:0]       last_idx;
    logic [IW-1:0]       push_idx;
    logic [IW+POS_W-1:0] s_pos_wide;
    logic [IW+POS_W-1:0] pos_wide;
    logic [CW+POS_W-1:0] pos_cmp;
    logic [CW+POS_W-1:0] count_cmp;

    assign count_dec  = count_reg - CW'(1);
    assign last_idx   = count_dec[IW-1:0];
    assign push_idx   = count_reg[IW-1:0];
    assign s_pos_wide = {{IW{1'b0}}, s_pos};
    assign pos_wide   = {{IW{1'b0}}, pos_reg};
    assign pos_cmp    = {{CW{1'b0}}, pos_reg};
    assign count_cmp  = {{POS_W{1'b0}}, count_reg};

    // Apply-step decode
    logic                  full, empty, in_range;
    status_t               status;
    logic                  take_read;
    cell_op_t              dec_op;
    logic [IW-1:0]         dec_idx;
    logic [CW-1:0]         dec_count;
    logic [DATA_WIDTH-1:0] read_word;
    logic [DATA_WIDTH+OUT_DATA_W-1:0] read_wide;
    logic [CW+COUNT_W-1:0] count_wide;

    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign in_range = (pos_cmp < count_cmp);

    always_comb begin
        status    = STATUS_OK;
        take_read = 1'b0;
        dec_op    = CELL_HOLD;
        dec_idx   = '0;
        dec_count = count_reg;
        unique case (kind_t'(kind_reg)) inside
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                if (full) begin
                    status = STATUS_FULL;
                end else begin
                    dec_count = count_reg + CW'(1);
                    if (kind_t'(kind_reg) == KIND_PUSH_FRONT) begin
                        dec_op  = CELL_SHIFT_UP;
                        dec_idx = '0;
                    end else begin
                        dec_op  = CELL_WRITE;
                        dec_idx = push_idx;
                    end
                end
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
                if (empty) begin
                    status = STATUS_EMPTY;
                end else begin
                    take_read = 1'b1;
                    dec_count = count_dec;
                    // popping the back only drops the count
                    if (kind_t'(kind_reg) == KIND_POP_FRONT) begin
                        dec_op  = CELL_SHIFT_DOWN;
                        dec_idx = '0;
                    end
                end
            end
            KIND_INSERT: begin
                if (!in_range) begin
                    status = STATUS_RANGE;
                end else if (full) begin
                    status = STATUS_FULL;
                end else begin
                    dec_op    = CELL_SHIFT_UP;
                    dec_idx   = pos_wide[IW-1:0];
                    dec_count = count_reg + CW'(1);
                end
            end
            KIND_DELETE: begin
                if (!in_range) begin
                    status = STATUS_RANGE;
                end else begin
                    dec_op    = CELL_SHIFT_DOWN;
                    dec_idx   = pos_wide[IW-1:0];
                    dec_count = count_dec;
                end
            end
            KIND_READ: begin
                if (!in_range) begin
                    status = STATUS_RANGE;
                end else begin
                    take_read = 1'b1;
                end
            end
            KIND_WRITE: begin
                if (!in_range) begin
                    status = STATUS_RANGE;
                end else begin
                    dec_op  = CELL_WRITE;
                    dec_idx = pos_wide[IW-1:0];
                end
            end
            KIND_READ_FRONT, KIND_READ_BACK: begin
                if (empty) begin
                    status = STATUS_EMPTY;
                end else begin
                    take_read = 1'b1;
                end
            end
            default: status = STATUS_OK;
        endcase
    end

    // Result beat assembly
    assign read_word  = take_read ? tree_root : '0;
    assign read_wide  = {{OUT_DATA_W{1'b0}}, read_word};
    assign count_wide = {{COUNT_W{1'b0}}, dec_count};

    always_comb begin
        m_data_next = '0;
        m_data_next[OUT_DATA_W-1:0] = read_wide[OUT_DATA_W-1:0];
        m_data_next[OUT_DATA_W+STATUS_W-1:OUT_DATA_W] = status;
        m_data_next[OUT_DATA_W+STATUS_W+COUNT_W-1:OUT_DATA_W+STATUS_W] =
            count_wide[COUNT_W-1:0];
        m_data_next[OUT_DATA_W+STATUS_W+COUNT_W] = (dec_count == '0);
    end

    // Read select, taken from the incoming beat and the current count
    always_comb begin
        unique case (kind_t'(s_kind)) inside
            KIND_POP_BACK, KIND_READ_BACK: sel_next = last_idx;
            KIND_READ:                     sel_next = s_pos_wide[IW-1:0];
            default:                       sel_next = '0;
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        wait_next  = wait_reg;
        unique case (state_reg)
            ST_IDLE: begin
                wait_next = '0;
                if (s_tvalid) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                wait_next = wait_reg + WAIT_W'(1);
                if (wait_reg == WAIT_W'(IW - 1)) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_tready     = 1'b0;
        load         = 1'b0;
        cell_ctl.op  = CELL_HOLD;
        cell_ctl.idx = '0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_WAIT: s_tready = 1'b0;
            ST_APPLY: begin
                load = !m_valid_reg || m_tready;
                if (load) begin
                    cell_ctl.op  = dec_op;
                    cell_ctl.idx = IDX_MAX_W'(dec_idx);
                end
            end
            default: s_tready = 1'b0;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wait_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wait_reg    <= wait_next;
            m_valid_reg <= m_valid_next;
            if (load) begin
                count_reg <= dec_count;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg  <= s_kind;
            pos_reg   <= s_pos;
            wdata_reg <= s_wdata_wide[DATA_WIDTH-1:0];
            sel_reg   <= sel_next;
        end
        if (load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Row of cells, each wired to its two neighbors
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] prev_w;
        logic [DATA_WIDTH-1:0] next_w;
        if (i == 0) begin : g_first
            assign prev_w = '0;
        end else begin : g_prev
            assign prev_w = cell_word[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign next_w = '0;
        end else begin : g_next
            assign next_w = cell_word[i+1];
        end
        ile_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (i)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (cell_ctl),
            .load_word (wdata_reg),
            .prev_word (prev_w),
            .next_word (next_w),
            .word      (cell_word[i])
        );
    end

    ile_read_tree #(
        .DATA_WIDTH (DATA_WIDTH),
        .CAPACITY   (CAPACITY)
    ) u_read_tree (
        .aclk      (aclk),
        .cell_word (cell_word),
        .sel       (sel_reg),
        .root      (tree_root)
    );

endmodule
